>>> rtl/core/boxds_pkg.sv
`timescale 1ns / 1ps

package boxds_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int LINE_DEPTH   = MAX_WIDTH / 2;

  localparam int DIM_W        = 13;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int SLOT_W       = $clog2(LINE_DEPTH);
  localparam int PIX_W        = 8;
  localparam int PAIR_W       = PIX_W + 1;
  localparam int SUM_W        = PIX_W + 2;

  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  // register index codes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  // raster position plus end-of-row / end-of-frame look-ahead
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             row_last;
    logic             frame_last;
  } pos_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    if (v < DIM_W'(2)) begin
      res = DIM_W'(2);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

>>> rtl/core/boxds_ram.sv
`timescale 1ns / 1ps

module boxds_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/boxds_pos.sv
`timescale 1ns / 1ps

module boxds_pos (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic                        restart,
  input  logic [boxds_pkg::DIM_W-1:0] width_cfg,
  input  logic [boxds_pkg::DIM_W-1:0] height_cfg,
  output boxds_pkg::pos_t             pos
);

  localparam int DW = boxds_pkg::DIM_W;

  logic [boxds_pkg::COL_W-1:0] col_r, col_nxt;
  logic [boxds_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [DW-1:0]               w, h;
  logic [DW-1:0]               col_inc, row_inc;

  assign w = boxds_pkg::clamp_dim(width_cfg,  DW'(boxds_pkg::MAX_WIDTH));
  assign h = boxds_pkg::clamp_dim(height_cfg, DW'(boxds_pkg::MAX_HEIGHT));

  assign col_inc = DW'(col_r) + DW'(1);
  assign row_inc = DW'(row_r) + DW'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (advance) begin
      if (col_inc >= w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h) ? '0 : row_inc[boxds_pkg::ROW_W-1:0];
      end else begin
        col_nxt = col_inc[boxds_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // last pair of a row / last pair row of a frame
  assign pos.col        = col_r;
  assign pos.row        = row_r;
  assign pos.row_last   = ((DW + 1)'(col_r) + (DW + 1)'(2)) >= (DW + 1)'(w);
  assign pos.frame_last = ((DW + 1)'(row_r) + (DW + 1)'(2)) >= (DW + 1)'(h);

endmodule

>>> rtl/core/box_downsample_2x2_core.sv
`timescale 1ns / 1ps
// 2x2 box downsampler, 8-bit plane, raster order in, one word per 2x2 block out.
// Throughput: one input word per cycle, sustained; output stalls back-pressure
//   the input only once both the read stage and the output register are full.
// A completed block passes stage 1 (line read), then the output register driving out_valid.
// Reset (rst_n, sync, active low): width 640, height 480, position at frame start,
//   no clearing pass; line store contents undefined until written on an even row.
module box_downsample_2x2_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // input pixel stream
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [boxds_pkg::PIX_W-1:0]      in_pixel,
  // averaged output stream
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [boxds_pkg::PIX_W-1:0]      out_avg_pixel,
  output logic                             out_row_end,
  output logic                             out_frame_end,
  // configuration (APB style)
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [boxds_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [boxds_pkg::APB_DATA_W-1:0] pwdata,
  output logic [boxds_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);

  localparam int DW = boxds_pkg::DIM_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Byte lanes of paddr are ignored; bit 2 picks the
  // register. Any write sends the raster position back to frame start.
  // ---------------------------------------------------------------------------
  logic [DW-1:0] width_r,  width_nxt;
  logic [DW-1:0] height_r, height_nxt;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      case (paddr[2])
        boxds_pkg::REG_WIDTH:  width_nxt  = pwdata[DW-1:0];
        boxds_pkg::REG_HEIGHT: height_nxt = pwdata[DW-1:0];
        default:               width_nxt  = width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= boxds_pkg::WIDTH_RESET;
      height_r <= boxds_pkg::HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      boxds_pkg::REG_WIDTH:  prdata = boxds_pkg::APB_DATA_W'(width_r);
      boxds_pkg::REG_HEIGHT: prdata = boxds_pkg::APB_DATA_W'(height_r);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake. Stage 1 holds a block whose line-store read is in flight; it
  // drains into the output register whenever that is empty or being taken.
  // The input stalls only when stage 1 is full and cannot drain.
  // ---------------------------------------------------------------------------
  logic in_acc;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_adv;
  logic out_valid_r, out_valid_nxt;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Raster position
  // ---------------------------------------------------------------------------
  boxds_pkg::pos_t pos;

  boxds_pos u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (in_acc),
    .restart    (cfg_wr),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .pos        (pos)
  );

  // ---------------------------------------------------------------------------
  // Pair sums. Even column: hold the left pixel. Odd column, even row: write
  // the pair sum to the line store. Odd column, odd row: read the stored sum.
  // A write and its matching read are always at least one row apart, so no
  // forwarding path is needed.
  // ---------------------------------------------------------------------------
  logic [boxds_pkg::PIX_W-1:0]  held_r, held_nxt;
  logic [boxds_pkg::PAIR_W-1:0] pair;
  logic [boxds_pkg::SLOT_W-1:0] slot;
  logic                         line_we, line_re;
  logic [boxds_pkg::PAIR_W-1:0] line_rdata;

  assign pair    = boxds_pkg::PAIR_W'(held_r) + boxds_pkg::PAIR_W'(in_pixel);
  assign slot    = pos.col[boxds_pkg::COL_W-1:1];
  assign line_we = in_acc && pos.col[0] && !pos.row[0];
  assign line_re = in_acc && pos.col[0] &&  pos.row[0];
  assign held_nxt = (in_acc && !pos.col[0]) ? in_pixel : held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  boxds_ram #(
    .WIDTH (boxds_pkg::PAIR_W),
    .DEPTH (boxds_pkg::LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (slot),
    .wdata (pair),
    .re    (line_re),
    .raddr (slot),
    .rdata (line_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: current pair and flags wait for the read word. The read port is
  // only enabled on accept, so line_rdata holds across a stall.
  // ---------------------------------------------------------------------------
  logic [boxds_pkg::PAIR_W-1:0] s1_pair_r;
  logic                         s1_rend_r;
  logic                         s1_fend_r;

  assign s1_valid_nxt = in_acc ? line_re : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (line_re) begin
      s1_pair_r <= pair;
      s1_rend_r <= pos.row_last;
      s1_fend_r <= pos.row_last && pos.frame_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: block sum, floor divide by four.
  // ---------------------------------------------------------------------------
  logic [boxds_pkg::SUM_W-1:0] sum;
  logic [boxds_pkg::PIX_W-1:0] avg_r;
  logic                        rend_r;
  logic                        fend_r;

  assign sum = boxds_pkg::SUM_W'(line_rdata) + boxds_pkg::SUM_W'(s1_pair_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      avg_r  <= sum[boxds_pkg::SUM_W-1:2];
      rend_r <= s1_rend_r;
      fend_r <= s1_fend_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_avg_pixel = avg_r;
  assign out_row_end   = rend_r;
  assign out_frame_end = fend_r;

endmodule

>>> test/box_downsample_2x2_checker.sv
`timescale 1ns / 1ps

module box_downsample_2x2_checker
  import boxds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [PIX_W-1:0]      out_avg_pixel,
  input  logic                  out_row_end,
  input  logic                  out_frame_end,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    error_count,
  output int                    pending,
  output int                    checked_count
);

  typedef struct packed {
    logic [PIX_W-1:0] avg;
    logic             row_end;
    logic             frame_end;
  } block_word_t;

  block_word_t       expected_blocks[$];
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [DIM_W-1:0]  col_pos;
  logic [DIM_W-1:0]  row_pos;
  logic [PIX_W-1:0]  held_left;
  logic [PAIR_W-1:0] pair_line [LINE_DEPTH];

  initial begin
    error_count   = 0;
    pending       = 0;
    checked_count = 0;
  end

  function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v, input int hi);
    if (v < 2) return DIM_W'(2);
    if (v > hi) return DIM_W'(hi);
    return v;
  endfunction

  // advance the raster by one pixel; queue a block word when a 2x2 completes
  task automatic fold_pixel(input logic [PIX_W-1:0] px);
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [PAIR_W-1:0] pair;
    logic [SUM_W-1:0]  sum;
    logic              last_in_row;
    block_word_t       blk;
    w = limit_dim(width_reg, MAX_WIDTH);
    h = limit_dim(height_reg, MAX_HEIGHT);
    if (!col_pos[0]) begin
      held_left = px;
    end else begin
      pair = held_left + px;
      if (!row_pos[0]) begin
        pair_line[col_pos >> 1] = pair;
      end else begin
        sum           = pair_line[col_pos >> 1] + pair;
        last_in_row   = (col_pos + 2 >= w);
        blk.avg       = sum[SUM_W-1:2];
        blk.row_end   = last_in_row;
        blk.frame_end = last_in_row && (row_pos + 2 >= h);
        expected_blocks.push_back(blk);
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = '0;
      row_pos = (row_pos + 1 >= h) ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  task automatic check_block();
    block_word_t want;
    if (expected_blocks.size() == 0) begin
      $display("%0t: unexpected output word: expected none, actual avg=%0d row_end=%0b frame_end=%0b",
               $time, out_avg_pixel, out_row_end, out_frame_end);
      error_count++;
      return;
    end
    want = expected_blocks.pop_front();
    checked_count++;
    if (out_avg_pixel !== want.avg) begin
      $display("%0t: avg_pixel mismatch: expected %0d, actual %0d",
               $time, want.avg, out_avg_pixel);
      error_count++;
    end
    if (out_row_end !== want.row_end) begin
      $display("%0t: row_end mismatch: expected %0b, actual %0b",
               $time, want.row_end, out_row_end);
      error_count++;
    end
    if (out_frame_end !== want.frame_end) begin
      $display("%0t: frame_end mismatch: expected %0b, actual %0b",
               $time, want.frame_end, out_frame_end);
      error_count++;
    end
  endtask

  // output side first: a word leaving now belongs to an older pixel
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col_pos    = '0;
      row_pos    = '0;
      held_left  = '0;
      expected_blocks.delete();
    end else begin
      if (out_valid && out_ready) check_block();
      if (in_valid && in_ready) fold_pixel(in_pixel);
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_WIDTH:  width_reg  = pwdata[DIM_W-1:0];
          REG_HEIGHT: height_reg = pwdata[DIM_W-1:0];
          default: ;
        endcase
        col_pos = '0;
        row_pos = '0;
      end
    end
    pending = expected_blocks.size();
  end

endmodule

>>> test/tb_box_downsample_2x2_core.sv
`timescale 1ns / 1ps

module tb_box_downsample_2x2_core;

  import boxds_pkg::*;

  // register map: register i at byte address 4*i
  localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR  = APB_ADDR_W'(4 * REG_WIDTH);
  localparam logic [APB_ADDR_W-1:0] HEIGHT_ADDR = APB_ADDR_W'(4 * REG_HEIGHT);
  localparam logic [APB_DATA_W-1:0] DIM_MASK    = APB_DATA_W'({DIM_W{1'b1}});

  // pixel budget of the random frame section
  localparam int RANDOM_ITEMS = 800;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIX_W-1:0]      out_avg_pixel;
  logic                  out_row_end;
  logic                  out_frame_end;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int error_count;
  int pending;
  int checked_count;

  // bookkeeping for the stimulus side
  int in_count     = 0;
  int cfg_writes   = 0;
  int src_calm     = 0;
  int sink_calm    = 0;
  bit long_hold_done = 1'b0;

  box_downsample_2x2_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_avg_pixel (out_avg_pixel),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // watches both streams and the config bus, predicts and compares
  box_downsample_2x2_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_avg_pixel (out_avg_pixel),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .error_count   (error_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Gap length between words. Mostly back-to-back or short, a few long ones,
  // and now and then a calm stretch of zero gaps so full-rate runs occur too.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      calm = $urandom_range(40, 160);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Pixel content: uniform most of the time, biased towards the rails
  // so full-scale sums and zero blocks turn up regularly.
  function automatic logic [PIX_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return PIX_W'($urandom_range(250, 255));
    return PIX_W'($urandom());
  endfunction

  // Offer one pixel word and hold it until accepted. Valid is only dropped
  // when a gap is actually taken, so back-to-back words keep valid high.
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_count++;
  endtask

  // Two-phase config write: setup, then access until pready. The trailing
  // edge keeps a following write from touching psel in the same step.
  task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  // Drain before touching the registers: every predicted word out, then an
  // extra wait, since trailing rows/columns can still be in flight
  // without any word owed for them.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // One configuration followed by n random pixels. Now and then junk goes
  // into the bits above the 13-bit dimension field.
  task automatic run_phase(input int w_raw, input int h_raw, input int n);
    logic [APB_DATA_W-1:0] junk;
    wait_idle();
    junk = ($urandom_range(0, 3) == 0) ? (APB_DATA_W'($urandom()) & ~DIM_MASK) : '0;
    cfg_write(WIDTH_ADDR, junk | APB_DATA_W'(w_raw));
    junk = ($urandom_range(0, 3) == 0) ? (APB_DATA_W'($urandom()) & ~DIM_MASK) : '0;
    cfg_write(HEIGHT_ADDR, junk | APB_DATA_W'(h_raw));
    repeat (n) send_pixel(pick_pixel());
  endtask

  // Receiver: ready runs of random length broken by random gaps, plus one
  // long forced hold-off once the random part is under way, so the block
  // fills and has to push back on the pixel stream.
  initial begin : sink
    int run;
    int gap;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!long_hold_done && in_count >= 300) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      run = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap(sink_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [PIX_W-1:0] tiny_frames [12];
    logic [PIX_W-1:0] odd_edges   [9];
    logic [PIX_W-1:0] clamped     [4];
    int               w;
    int               h;
    int               w_raw;
    int               h_raw;
    int               n;
    int               random_sent;

    in_valid <= 1'b0;
    in_pixel <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    rst_n    <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // 2x2 frames: all-white, all-black, and a sum of 3 that must floor to 0
    tiny_frames = '{8'd255, 8'd255, 8'd255, 8'd255,
                    8'd0,   8'd0,   8'd0,   8'd0,
                    8'd3,   8'd0,   8'd0,   8'd0};
    wait_idle();
    cfg_write(WIDTH_ADDR, 2);
    cfg_write(HEIGHT_ADDR, 2);
    foreach (tiny_frames[i]) send_pixel(tiny_frames[i]);

    // 3x3: last column and last row are swallowed, one word only
    odd_edges = '{8'd10, 8'd20, 8'd99,
                  8'd30, 8'd40, 8'd99,
                  8'd99, 8'd99, 8'd99};
    wait_idle();
    cfg_write(WIDTH_ADDR, 3);
    cfg_write(HEIGHT_ADDR, 3);
    foreach (odd_edges[i]) send_pixel(odd_edges[i]);

    // dimensions below the minimum behave as 2
    clamped = '{8'd200, 8'd201, 8'd202, 8'd203};
    wait_idle();
    cfg_write(WIDTH_ADDR, 0);
    cfg_write(HEIGHT_ADDR, 1);
    foreach (clamped[i]) send_pixel(clamped[i]);

    // --- random small frames, sometimes cut short by the next config ---
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 70) : $urandom_range(2, 20);
      h = $urandom_range(2, 9);
      n = w * h * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) n += $urandom_range(1, w * h - 1);
      if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
      w_raw = (w == 2 && $urandom_range(0, 1) == 1) ? $urandom_range(0, 1) : w;
      h_raw = (h == 2 && $urandom_range(0, 1) == 1) ? $urandom_range(0, 1) : h;
      run_phase(w_raw, h_raw, n);
      random_sent += n;
    end

    // --- values above the maximum, cut short ---
    // 4097 clamps to 4096 wide: one partial even row
    run_phase(4097, 2, 64);
    // 8191 clamps to 4096 rows on a narrow frame
    run_phase(2, 8191, 64);

    wait_idle();
    $display("Run covered %0d pixel words over %0d register writes;",
             in_count, cfg_writes);
    $display("%0d averaged words compared, small and odd frames, clamped sizes, long stall.",
             checked_count);
    if (error_count == 0) begin
      $display("** box_downsample_2x2_core: PASSED **");
    end else begin
      $display("** box_downsample_2x2_core: FAILED **");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(64'd240_000_000);
    $display("** box_downsample_2x2_core: FAILED **");
    $finish;
  end

endmodule
